// ===== sv/cdmc_pkg.sv =====
// Shared types, widths and calibration tables for the dual motor command block.
// Used by cdmc_lookup and calibrated_dual_motor_command; depends on nothing.
`timescale 1ns / 1ps

package cdmc_pkg;

    localparam int CAL_POINTS = 13;
    localparam int DUTY_BITS  = 10;

    localparam int VEL_W  = 12;                 // velocity command
    localparam int X_W    = 11;                 // breakpoint
    localparam int Y_W    = 9;                  // duty point
    localparam int IDX_W  = $clog2(CAL_POINTS);
    localparam int DY_W   = Y_W + 1;            // difference of two duty points
    localparam int SPAN_W = X_W;                // positive segment span
    localparam int DV_W   = X_W;                // offset into a segment, never above span
    localparam int PROD_W = DY_W + DV_W;
    localparam int QUO_W  = DY_W;               // quotient never exceeds |dy|
    localparam int RES_W  = Y_W + 2;            // interpolated value
    localparam int SAT_W  = (RES_W > DUTY_BITS) ? RES_W : DUTY_BITS;
    localparam int CNT_W  = $clog2(QUO_W);

    localparam logic [DUTY_BITS-1:0] DUTY_MAX = '1;

    typedef logic signed [X_W-1:0] t_xpt;
    typedef logic signed [Y_W-1:0] t_ypt;

    localparam t_xpt SPEED_BP [CAL_POINTS] = '{
        -11'sd1000, -11'sd500, -11'sd300, -11'sd200, -11'sd100, -11'sd1, 11'sd0,
        11'sd1, 11'sd100, 11'sd200, 11'sd300, 11'sd500, 11'sd1000
    };

    localparam t_ypt DUTY_A [CAL_POINTS] = '{
        -9'sd232, -9'sd130, -9'sd85, -9'sd64, -9'sd41, -9'sd30, 9'sd30,
        9'sd0, 9'sd34, 9'sd55, 9'sd75, 9'sd118, 9'sd223
    };

    localparam t_ypt DUTY_B [CAL_POINTS] = '{
        -9'sd227, -9'sd118, -9'sd76, -9'sd55, -9'sd34, -9'sd16, 9'sd0,
        9'sd25, 9'sd33, 9'sd55, 9'sd75, 9'sd119, 9'sd225
    };

    typedef struct packed {
        logic signed [VEL_W-1:0] left_velocity;
        logic signed [VEL_W-1:0] right_velocity;
    } t_cmd_word;

    typedef struct packed {
        logic                 standby_on;
        logic                 left_forward;
        logic                 right_forward;
        logic [DUTY_BITS-1:0] left_duty;
        logic [DUTY_BITS-1:0] right_duty;
        logic                 updated;
    } t_res_word;

    // Request from the sequencer to the lookup unit; motor 0 is left, 1 is right.
    typedef struct packed {
        logic start;
        logic motor;
    } t_lkp_req;

    typedef struct packed {
        logic                 done;
        logic [DUTY_BITS-1:0] duty;
    } t_lkp_stat;

    function automatic t_ypt duty_pt(input logic motor, input logic [IDX_W-1:0] idx);
        duty_pt = motor ? DUTY_B[idx] : DUTY_A[idx];
    endfunction

    // Absolute value, saturated to the duty range.
    function automatic logic [DUTY_BITS-1:0] to_duty(input logic signed [RES_W-1:0] val);
        logic [RES_W-1:0] mag;
        logic [SAT_W-1:0] wide;
        mag  = val[RES_W-1] ? RES_W'(-val) : RES_W'(val);
        wide = SAT_W'(mag);
        if (wide > SAT_W'(DUTY_MAX)) begin
            to_duty = DUTY_MAX;
        end else begin
            to_duty = DUTY_BITS'(wide);
        end
    endfunction

endpackage

// ===== sv/calibrated_dual_motor_command.sv =====
// Dual motor command: standby, direction and calibrated PWM duty per velocity pair.
// An unchanged pair goes straight to the output state; a changed pair runs the shared
// lookup unit twice, left then right (segment search, multiply, bit-serial divide).
// Throughput: one word at a time; the input stalls until the result is in the output register.
// Reset (synchronous, active low): held commands, directions and duties clear to zero.
// Depends on cdmc_pkg and cdmc_lookup.
`timescale 1ns / 1ps

module calibrated_dual_motor_command (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  cdmc_pkg::t_cmd_word    i_in_word,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output cdmc_pkg::t_res_word    o_out_word
);

    localparam int VEL_W     = cdmc_pkg::VEL_W;
    localparam int DUTY_BITS = cdmc_pkg::DUTY_BITS;

    // Sequencer: IDLE takes a word, LEFT and RIGHT each run one lookup,
    // OUT waits for room in the output register.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LEFT  = 4'b0010,
        ST_RIGHT = 4'b0100,
        ST_OUT   = 4'b1000
    } t_top_state;

    t_top_state                 r_state, n_state;
    logic signed [VEL_W-1:0]    r_prev_left, n_prev_left;
    logic signed [VEL_W-1:0]    r_prev_right, n_prev_right;
    logic [1:0]                 r_dirs, n_dirs;          // bit 0 left, bit 1 right
    logic [DUTY_BITS-1:0]       r_left_duty, n_left_duty;
    logic [DUTY_BITS-1:0]       r_right_duty, n_right_duty;
    logic                       r_standby, n_standby;
    logic                       r_updated, n_updated;
    cdmc_pkg::t_lkp_req         r_req, n_req;
    logic signed [VEL_W-1:0]    r_vel, n_vel;
    logic                       r_out_valid, n_out_valid;
    cdmc_pkg::t_res_word        r_out_word, n_out_word;

    cdmc_pkg::t_lkp_stat        w_stat;
    logic                       w_in_acc;
    logic                       w_out_free;
    logic                       w_changed;

    cdmc_lookup u_lookup (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (r_req),
        .i_velocity (r_vel),
        .o_stat     (w_stat)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_changed  = (i_in_word.left_velocity != r_prev_left) ||
                        (i_in_word.right_velocity != r_prev_right);

    always_comb begin
        n_state      = r_state;
        n_prev_left  = r_prev_left;
        n_prev_right = r_prev_right;
        n_dirs       = r_dirs;
        n_left_duty  = r_left_duty;
        n_right_duty = r_right_duty;
        n_standby    = r_standby;
        n_updated    = r_updated;
        n_req.start  = 1'b0;
        n_req.motor  = r_req.motor;
        n_vel        = r_vel;
        n_out_word   = r_out_word;
        // drop the output word once taken
        n_out_valid  = r_out_valid && i_out_stall;

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_standby = (i_in_word.left_velocity == '0) &&
                                (i_in_word.right_velocity == '0);
                    if (w_changed) begin
                        // latch the new pair and directions, then start the left lookup
                        n_prev_left  = i_in_word.left_velocity;
                        n_prev_right = i_in_word.right_velocity;
                        n_dirs[0]    = (i_in_word.left_velocity > 0);
                        n_dirs[1]    = (i_in_word.right_velocity > 0);
                        n_updated    = 1'b1;
                        n_req.start  = 1'b1;
                        n_req.motor  = 1'b0;
                        n_vel        = i_in_word.left_velocity;
                        n_state      = ST_LEFT;
                    end else begin
                        // same pair as before: hold everything, report no update
                        n_updated = 1'b0;
                        n_state   = ST_OUT;
                    end
                end
            end
            ST_LEFT: begin
                if (w_stat.done) begin
                    n_left_duty = w_stat.duty;
                    n_req.start = 1'b1;
                    n_req.motor = 1'b1;
                    n_vel       = r_prev_right;
                    n_state     = ST_RIGHT;
                end
            end
            ST_RIGHT: begin
                if (w_stat.done) begin
                    n_right_duty = w_stat.duty;
                    n_state      = ST_OUT;
                end
            end
            ST_OUT: begin
                // advance into the output register as soon as it has room
                if (w_out_free) begin
                    n_out_word.standby_on    = r_standby;
                    n_out_word.left_forward  = r_dirs[0];
                    n_out_word.right_forward = r_dirs[1];
                    n_out_word.left_duty     = r_left_duty;
                    n_out_word.right_duty    = r_right_duty;
                    n_out_word.updated       = r_updated;
                    n_out_valid              = 1'b1;
                    n_state                  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_prev_left  <= '0;
            r_prev_right <= '0;
            r_dirs       <= '0;
            r_left_duty  <= '0;
            r_right_duty <= '0;
            r_req        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_prev_left  <= n_prev_left;
            r_prev_right <= n_prev_right;
            r_dirs       <= n_dirs;
            r_left_duty  <= n_left_duty;
            r_right_duty <= n_right_duty;
            r_req        <= n_req;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_standby  <= n_standby;
        r_updated  <= n_updated;
        r_vel      <= n_vel;
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // A lookup result only arrives while the sequencer waits for one.
    a_done_in_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> (r_state == ST_LEFT || r_state == ST_RIGHT))
        else $error("lookup result outside a lookup state");

    // A taken word closes the input until its result is registered.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("input open straight after accepting a word");

    // The lookup unit never answers in the cycle after a start.
    a_start_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req.start |=> !w_stat.done)
        else $error("lookup result too early after start");

endmodule

// ===== sv/cdmc_lookup.sv =====
// Shared piecewise-linear lookup unit: segment search, one multiply, bit-serial divide.
// Depends on cdmc_pkg.
`timescale 1ns / 1ps

module cdmc_lookup (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  cdmc_pkg::t_lkp_req                      i_req,
    input  logic signed [cdmc_pkg::VEL_W-1:0]       i_velocity,
    output cdmc_pkg::t_lkp_stat                     o_stat
);

    localparam int VEL_W  = cdmc_pkg::VEL_W;
    localparam int X_W    = cdmc_pkg::X_W;
    localparam int IDX_W  = cdmc_pkg::IDX_W;
    localparam int DY_W   = cdmc_pkg::DY_W;
    localparam int SPAN_W = cdmc_pkg::SPAN_W;
    localparam int DV_W   = cdmc_pkg::DV_W;
    localparam int PROD_W = cdmc_pkg::PROD_W;
    localparam int QUO_W  = cdmc_pkg::QUO_W;
    localparam int RES_W  = cdmc_pkg::RES_W;
    localparam int CNT_W  = cdmc_pkg::CNT_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SEARCH = 6'b000010,
        S_MUL    = 6'b000100,
        S_LOAD   = 6'b001000,
        S_DIV    = 6'b010000,
        S_FIN    = 6'b100000
    } t_lkp_state;

    t_lkp_state                          r_state, n_state;
    logic signed [VEL_W-1:0]             r_vel, n_vel;
    logic                                r_motor, n_motor;
    logic [IDX_W-1:0]                    r_idx, n_idx;
    logic [PROD_W-1:0]                   r_prod, n_prod;
    logic                                r_neg, n_neg;
    logic [SPAN_W-1:0]                   r_span, n_span;
    cdmc_pkg::t_ypt                      r_base, n_base;
    logic [SPAN_W-1:0]                   r_rem, n_rem;
    logic [QUO_W-1:0]                    r_qd, n_qd;
    logic [CNT_W-1:0]                    r_cnt, n_cnt;
    logic                                r_done, n_done;
    logic [cdmc_pkg::DUTY_BITS-1:0]      r_duty, n_duty;

    logic [IDX_W-1:0]                    w_idx_nx;
    cdmc_pkg::t_xpt                      w_x_lo, w_x_hi;
    cdmc_pkg::t_ypt                      w_y_lo, w_y_hi;
    logic signed [DY_W-1:0]              w_dy;
    logic [DY_W-1:0]                     w_dy_mag;
    logic signed [X_W:0]                 w_span_s;
    logic signed [VEL_W:0]               w_dv_s;
    logic [PROD_W-1:0]                   w_prod;
    logic [SPAN_W:0]                     w_sh;
    logic                                w_fit;
    logic signed [RES_W-1:0]             w_res;

    assign w_idx_nx = r_idx + IDX_W'(1);
    assign w_x_lo   = cdmc_pkg::SPEED_BP[r_idx];
    assign w_x_hi   = cdmc_pkg::SPEED_BP[w_idx_nx];
    assign w_y_lo   = cdmc_pkg::duty_pt(r_motor, r_idx);
    assign w_y_hi   = cdmc_pkg::duty_pt(r_motor, w_idx_nx);
    assign w_dy     = DY_W'(w_y_hi) - DY_W'(w_y_lo);
    assign w_dy_mag = w_dy[DY_W-1] ? DY_W'(-w_dy) : DY_W'(w_dy);
    assign w_span_s = (X_W+1)'(w_x_hi) - (X_W+1)'(w_x_lo);
    assign w_dv_s   = (VEL_W+1)'(r_vel) - (VEL_W+1)'(w_x_lo);
    assign w_prod   = PROD_W'(w_dy_mag) * PROD_W'(w_dv_s[DV_W-1:0]);

    // one restoring step per cycle
    assign w_sh  = {r_rem, r_qd[QUO_W-1]};
    assign w_fit = (w_sh >= {1'b0, r_span});

    assign w_res = r_neg ? (RES_W'(r_base) - RES_W'(r_qd)) : (RES_W'(r_base) + RES_W'(r_qd));

    always_comb begin
        n_state = r_state;
        n_vel   = r_vel;
        n_motor = r_motor;
        n_idx   = r_idx;
        n_prod  = r_prod;
        n_neg   = r_neg;
        n_span  = r_span;
        n_base  = r_base;
        n_rem   = r_rem;
        n_qd    = r_qd;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_duty  = r_duty;
        case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_vel   = i_velocity;
                    n_motor = i_req.motor;
                    n_qd    = '0;
                    n_neg   = 1'b0;
                    if (i_velocity > cdmc_pkg::SPEED_BP[cdmc_pkg::CAL_POINTS-1]) begin
                        n_base  = cdmc_pkg::duty_pt(i_req.motor,
                                                   IDX_W'(cdmc_pkg::CAL_POINTS-1));
                        n_state = S_FIN;
                    end else if (i_velocity <= cdmc_pkg::SPEED_BP[0]) begin
                        n_base  = cdmc_pkg::duty_pt(i_req.motor, IDX_W'(0));
                        n_state = S_FIN;
                    end else begin
                        n_idx   = IDX_W'(cdmc_pkg::CAL_POINTS-2);
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                // walk down until the breakpoint lies below the command
                if (w_x_lo < r_vel) begin
                    n_state = S_MUL;
                end else begin
                    n_idx = r_idx - IDX_W'(1);
                end
            end
            S_MUL: begin
                n_base = w_y_lo;
                if (w_span_s <= 0) begin
                    n_qd    = '0;
                    n_neg   = 1'b0;
                    n_state = S_FIN;
                end else begin
                    n_prod  = w_prod;
                    n_neg   = w_dy[DY_W-1];
                    n_span  = w_span_s[SPAN_W-1:0];
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                // quotient fits QUO_W bits, so the top of the product is below the span
                n_rem   = r_prod[PROD_W-1:QUO_W];
                n_qd    = r_prod[QUO_W-1:0];
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = w_fit ? SPAN_W'(w_sh - {1'b0, r_span}) : w_sh[SPAN_W-1:0];
                n_qd  = {r_qd[QUO_W-2:0], w_fit};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(QUO_W-1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_duty  = cdmc_pkg::to_duty(w_res);
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vel   <= n_vel;
        r_motor <= n_motor;
        r_idx   <= n_idx;
        r_prod  <= n_prod;
        r_neg   <= n_neg;
        r_span  <= n_span;
        r_base  <= n_base;
        r_rem   <= n_rem;
        r_qd    <= n_qd;
        r_cnt   <= n_cnt;
        r_duty  <= n_duty;
    end

    assign o_stat.done = r_done;
    assign o_stat.duty = r_duty;

endmodule

// ===== verif/tb.sv =====
// Self-checking bench for calibrated_dual_motor_command: directed and random velocity pairs,
// with predicted standby, direction and calibrated duty for every result word.
// Depends on cdmc_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT  = 800000;  // far above the slowest legal run
    localparam int RANDOM_WORDS = 1700;
    localparam int SETTLE_TAIL  = 100;     // longer than the slowest lookup pair

    // A queued command word; drain_first holds it back until every result is home.
    typedef struct packed {
        logic                drain_first;
        cdmc_pkg::t_cmd_word word;
    } t_stim;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    cdmc_pkg::t_cmd_word i_in_word = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    cdmc_pkg::t_res_word o_out_word;

    calibrated_dual_motor_command dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always #10 i_clk = ~i_clk;

    // Calibration tables: speed breakpoints and the signed duty points of each motor.
    int bp_speed  [13] = '{-1000, -500, -300, -200, -100, -1, 0, 1, 100, 200, 300, 500, 1000};
    int cal_left  [13] = '{-232, -130, -85, -64, -41, -30, 30, 0, 34, 55, 75, 118, 223};
    int cal_right [13] = '{-227, -118, -76, -55, -34, -16, 0, 25, 33, 55, 75, 119, 225};

    // Predicted block state: last command pair that caused an update, held outputs.
    int                             last_left = 0;
    int                             last_right = 0;
    logic                           fwd_left = 1'b0;
    logic                           fwd_right = 1'b0;
    logic [cdmc_pkg::DUTY_BITS-1:0] duty_left = '0;
    logic [cdmc_pkg::DUTY_BITS-1:0] duty_right = '0;

    t_stim               cmd_queue [$];
    cdmc_pkg::t_res_word result_queue [$];

    int  cycle_count = 0;
    int  errors = 0;
    int  words_sent = 0;
    int  results_checked = 0;
    int  updates_seen = 0;
    int  standby_seen = 0;
    int  hold_left = 0;
    int  last_hold_mark = -1;

    // Quiet stretches: neither side idles nor stalls at random in one window out of five.
    wire calm = ((cycle_count / 4000) % 5) == 2;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still due", cycle_count,
                     result_queue.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Truncating piecewise-linear lookup, magnitude taken and saturated to the duty range.
    // Below or at the first breakpoint the first point applies, above the last the last one.
    function automatic logic [cdmc_pkg::DUTY_BITS-1:0] calibrated_duty(input int v,
                                                                        input logic right);
        int i;
        int y0;
        int y1;
        int span;
        int r;
        r = right ? cal_right[0] : cal_left[0];
        if (v > bp_speed[12]) begin
            r = right ? cal_right[12] : cal_left[12];
        end else if (v > bp_speed[0]) begin
            i = 11;
            while (bp_speed[i] >= v) i--;
            y0   = right ? cal_right[i] : cal_left[i];
            y1   = right ? cal_right[i+1] : cal_left[i+1];
            span = bp_speed[i+1] - bp_speed[i];
            // a flat or falling segment keeps its left point
            r = (span <= 0) ? y0 : y0 + ((y1 - y0) * (v - bp_speed[i])) / span;
        end
        if (r < 0) r = -r;
        if (r > 2**cdmc_pkg::DUTY_BITS - 1) r = 2**cdmc_pkg::DUTY_BITS - 1;
        return r[cdmc_pkg::DUTY_BITS-1:0];
    endfunction

    // Advance the predicted state by one command word and return the result it causes.
    function automatic cdmc_pkg::t_res_word motor_response(input cdmc_pkg::t_cmd_word w);
        cdmc_pkg::t_res_word r;
        int                  l;
        int                  rv;
        l  = w.left_velocity;
        rv = w.right_velocity;
        r.standby_on = (l == 0 && rv == 0);
        r.updated    = 1'b0;
        if (l != last_left || rv != last_right) begin
            fwd_left   = l > 0;
            fwd_right  = rv > 0;
            duty_left  = calibrated_duty(l, 1'b0);
            duty_right = calibrated_duty(rv, 1'b1);
            last_left  = l;
            last_right = rv;
            r.updated  = 1'b1;
        end
        r.left_forward  = fwd_left;
        r.right_forward = fwd_right;
        r.left_duty     = duty_left;
        r.right_duty    = duty_right;
        return r;
    endfunction

    // Mix of full-range values, breakpoint neighbours, values near zero and the table span.
    function automatic int rand_velocity();
        case ($urandom_range(9))
            0, 1:    return int'($urandom_range(4095)) - 2048;
            2:       return bp_speed[$urandom_range(12)] + int'($urandom_range(2)) - 1;
            3:       return int'($urandom_range(6)) - 3;
            default: return int'($urandom_range(2200)) - 1100;
        endcase
    endfunction

    task automatic queue_pair(input int l, input int r, input logic drain);
        t_stim s;
        s.drain_first          = drain;
        s.word.left_velocity   = l[cdmc_pkg::VEL_W-1:0];
        s.word.right_velocity  = r[cdmc_pkg::VEL_W-1:0];
        cmd_queue.push_back(s);
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name,
                     exp_val, act_val);
            errors++;
        end
    endtask

    // Driver: predict each word as it is accepted, then hold, idle or offer the next one.
    always @(posedge i_clk) begin
        logic                nv;
        cdmc_pkg::t_cmd_word nw;
        nv = i_in_valid;
        nw = i_in_word;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                result_queue.push_back(motor_response(i_in_word));
                words_sent++;
                nv = 1'b0;
            end
            if (!nv && cmd_queue.size() > 0) begin
                if (cmd_queue[0].drain_first && result_queue.size() > 0) begin
                    nv = 1'b0;            // hold until every result is home
                end else if (!calm && $urandom_range(99) < 30) begin
                    nv = 1'b0;            // idle this cycle
                end else begin
                    nw = cmd_queue[0].word;
                    cmd_queue.pop_front();
                    nv = 1'b1;
                end
            end
        end
        i_in_valid <= nv;
        i_in_word  <= nw;
    end

    // Monitor: check each accepted result word against the oldest prediction, then
    // choose the next stall. Twice in the run, hold the output off for a long stretch
    // while the sender keeps offering, so that the block backs up into its input.
    always @(posedge i_clk) begin
        logic                ns;
        cdmc_pkg::t_res_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (result_queue.size() == 0) begin
                $display("%0t ns: unexpected result word, expected none, actual %h", $time,
                         o_out_word);
                errors++;
            end else begin
                want = result_queue.pop_front();
                check_field("standby_on", want.standby_on, o_out_word.standby_on);
                check_field("left_forward", want.left_forward, o_out_word.left_forward);
                check_field("right_forward", want.right_forward, o_out_word.right_forward);
                check_field("left_duty", want.left_duty, o_out_word.left_duty);
                check_field("right_duty", want.right_duty, o_out_word.right_duty);
                check_field("updated", want.updated, o_out_word.updated);
                updates_seen += want.updated;
                standby_seen += want.standby_on;
            end
            results_checked++;
        end
        if (hold_left > 0) begin
            hold_left--;
            ns = 1'b1;
        end else if ((results_checked == 300 || results_checked == 1200)
                     && results_checked != last_hold_mark) begin
            last_hold_mark = results_checked;
            hold_left      = 250;
            ns             = 1'b1;
        end else begin
            ns = !calm && ($urandom_range(99) < 30);
        end
        i_out_stall <= ns;
    end

    initial begin
        int n;
        int kind;
        int l;
        int r;

        // Directed words: zero pair straight after reset (no update), range extremes,
        // both table ends and just past them, the zero-crossing segments, an unchanged
        // repeat, a return to standby and a change on one side only.
        queue_pair(0, 0, 1'b0);
        queue_pair(0, 0, 1'b0);
        queue_pair(-2048, 2047, 1'b0);
        queue_pair(2047, -2048, 1'b0);
        queue_pair(-1000, -1000, 1'b0);
        queue_pair(-999, -1001, 1'b0);
        queue_pair(1000, 1000, 1'b0);
        queue_pair(1001, 999, 1'b0);
        queue_pair(-1, 0, 1'b0);
        queue_pair(0, 1, 1'b0);
        queue_pair(1, -1, 1'b0);
        queue_pair(50, -50, 1'b0);
        queue_pair(-150, 150, 1'b0);
        queue_pair(-400, 250, 1'b0);
        queue_pair(750, -750, 1'b0);
        queue_pair(750, -750, 1'b0);
        queue_pair(0, 0, 1'b0);
        queue_pair(0, 5, 1'b0);
        queue_pair(-2048, -2048, 1'b0);
        queue_pair(2047, 2047, 1'b0);
        queue_pair(-1024, 1023, 1'b0);
        queue_pair(-500, -300, 1'b0);
        queue_pair(100, 200, 1'b1);

        // Random words: repeats, one-sided changes, returns to zero and fresh pairs.
        l = 100;
        r = 200;
        for (n = 0; n < RANDOM_WORDS; n++) begin
            kind = $urandom_range(99);
            if (kind < 20) begin
                // repeat the last pair unchanged
            end else if (kind < 30) begin
                if ($urandom_range(1)) l = rand_velocity();
                else r = rand_velocity();
            end else if (kind < 33) begin
                l = 0;
                r = 0;
            end else begin
                l = rand_velocity();
                r = rand_velocity();
            end
            queue_pair(l, r, (n % 400) == 200);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every word to go in and every result to come back, then let the
        // block settle so that any stray word still shows up.
        do @(negedge i_clk);
        while (cmd_queue.size() != 0 || i_in_valid || result_queue.size() != 0);
        repeat (SETTLE_TAIL) @(negedge i_clk);

        $display("Sent %0d command words; checked %0d results, %0d with an update, %0d in standby",
                 words_sent, results_checked, updates_seen, standby_seen);
        $display("Covered table ends, breakpoint neighbours, full-range extremes and back-pressure");
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
